### design/cssc_pkg.sv
// ----------------------------------------------------------------------------
// cssc_pkg
// Shared types and constants of the cycling speed and cadence calculator.
// ----------------------------------------------------------------------------
package cssc_pkg;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WHEEL_CIRC    = 2'd0;
    localparam t_cfg_idx CFG_SPEED_HOLD    = 2'd1;
    localparam t_cfg_idx CFG_CADENCE_HOLD  = 2'd2;

    // configuration reset values
    localparam logic [15:0] WHEEL_CIRC_RST   = 16'd2000;
    localparam logic [15:0] SPEED_HOLD_RST   = 16'd2;
    localparam logic [15:0] CADENCE_HOLD_RST = 16'd2;

    // divider widths
    localparam int unsigned NUM_W = 62;
    localparam int unsigned DEN_W = 21;
    localparam int unsigned QUO_W = 16;

    // request into the shared divider
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    // response from the shared divider
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

### design/cssc_div.sv
// ----------------------------------------------------------------------------
// cssc_div
// Restoring divider, one quotient bit per cycle, saturating at 16 bits.
// ----------------------------------------------------------------------------
module cssc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cssc_pkg::t_div_req i_req,
    output cssc_pkg::t_div_rsp o_rsp
);
    import cssc_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_ITER
    } t_dstate;

    t_dstate          r_state;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_ql;
    logic [3:0]       r_cnt;
    logic [QUO_W-1:0] r_quo;
    logic             r_done;

    logic [DEN_W+1:0] n_trial;
    logic             n_qbit;
    logic [DEN_W-1:0] n_rem;
    logic             n_sat;

    // one trial subtract per cycle; next numerator bit comes from the top of r_ql
    always_comb begin
        n_trial = {1'b0, r_rem, r_ql[QUO_W-1]} - {2'b00, r_den};
        n_qbit  = ~n_trial[DEN_W+1];
        n_rem   = n_qbit ? n_trial[DEN_W-1:0] : {r_rem[DEN_W-2:0], r_ql[QUO_W-1]};
        // quotient does not fit in 16 bits
        n_sat   = (r_num >= {{(NUM_W-DEN_W-QUO_W){1'b0}}, r_den, {QUO_W{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_num   <= i_req.num;
                        r_den   <= i_req.den;
                        r_state <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    if (n_sat) begin
                        r_quo   <= {QUO_W{1'b1}};
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        // upper part is already below the divisor
                        r_rem   <= r_num[DEN_W+QUO_W-1:QUO_W];
                        r_ql    <= r_num[QUO_W-1:0];
                        r_cnt   <= '0;
                        r_state <= D_ITER;
                    end
                end
                D_ITER: begin
                    r_rem <= n_rem;
                    r_ql  <= {r_ql[QUO_W-2:0], n_qbit};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_quo   <= {r_ql[QUO_W-2:0], n_qbit};
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### design/cycling_speed_cadence_calc_unit.sv
// ----------------------------------------------------------------------------
// cycling_speed_cadence_calc_unit
// Speed, cadence and distance from parsed speed-and-cadence measurements.
// ----------------------------------------------------------------------------
// Throughput: one item at a time, next item taken the cycle after the result
//   is loaded (later while the result is stalled); the 16-step shared divider,
//   run at most once each for speed and cadence, sets it.
// Reset: synchronous, active low; control and measurement state cleared, configuration registers to defaults.
// ----------------------------------------------------------------------------
module cycling_speed_cadence_calc_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  cssc_pkg::t_cfg_idx    i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic                  i_wheel_present,
    input  logic                  i_crank_present,
    input  logic [31:0]           i_wheel_revs,
    input  logic [15:0]           i_wheel_event_time,
    input  logic [15:0]           i_crank_revs,
    input  logic [15:0]           i_crank_event_time,
    input  logic [31:0]           i_now_seconds,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_speed_centi_kmh,
    output logic [15:0]           o_cadence_rpm,
    output logic [47:0]           o_session_distance_mm,
    output logic [47:0]           o_total_distance_mm,
    output logic                  o_speed_valid,
    output logic                  o_cadence_valid
);
    import cssc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_WHEEL,
        S_WHOLD,
        S_WADD,
        S_WMUL,
        S_WNUM,
        S_WSTART,
        S_WDIV,
        S_CRANK,
        S_CHOLD,
        S_CSTART,
        S_CDIV,
        S_DLO,
        S_DHI,
        S_DTOT,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_circ;
    logic [15:0] r_speed_hold;
    logic [15:0] r_cad_hold;

    // latched item
    logic        r_cmd;
    logic        r_wp;
    logic        r_cp;
    logic [31:0] r_wrevs;
    logic [15:0] r_wtime;
    logic [15:0] r_crevs;
    logic [15:0] r_ctime;
    logic [31:0] r_now;

    // measurement state
    logic [31:0] r_last_wheel_count;
    logic [15:0] r_last_wheel_ticks;
    logic        r_speed_started;
    logic [15:0] r_held_speed;
    logic [31:0] r_wheel_seen_time;
    logic [31:0] r_last_nonzero_rounds;
    logic [39:0] r_session_wheel_count;
    logic [15:0] r_last_crank_count;
    logic [15:0] r_last_crank_ticks;
    logic        r_cadence_started;
    logic [15:0] r_held_cadence;
    logic [31:0] r_crank_seen_time;

    // working registers
    logic [31:0]      r_rounds;
    logic [15:0]      r_ticks;
    logic             r_hold;
    logic [47:0]      r_prod;
    logic [47:0]      r_sess_dist;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;

    // output register
    logic        r_out_valid;
    logic [15:0] r_o_speed;
    logic [15:0] r_o_cadence;
    logic [47:0] r_o_sess;
    logic [47:0] r_o_total;
    logic        r_o_sv;
    logic        r_o_cv;

    // combinational helpers
    logic [32:0] n_wdiff;
    logic [15:0] n_cdiff;
    logic [31:0] n_welapsed;
    logic [31:0] n_celapsed;
    logic        n_rz;
    logic [31:0] n_mul_b;
    logic [47:0] n_mul;
    logic [51:0] n_times9;
    logic [31:0] n_cnum;
    logic        n_in_acc;
    logic        n_out_load;
    t_div_req    n_div_req;
    t_div_rsp    n_div_rsp;

    assign n_in_acc   = i_in_valid && !o_in_stall;
    assign n_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // differences, elapsed times, numerator terms; a backward wheel step (n_wdiff[32]) counts as zero
    always_comb begin
        n_wdiff    = {1'b0, r_wrevs} - {1'b0, r_last_wheel_count};
        n_cdiff    = r_crevs - r_last_crank_count;
        n_welapsed = r_now - r_wheel_seen_time;
        n_celapsed = r_now - r_crank_seen_time;
        n_rz       = (r_ticks == 16'd0) || (r_rounds == 32'd0);
        n_times9   = {1'b0, r_prod, 3'b000} + {4'b0000, r_prod};
        n_cnum     = {r_rounds[15:0], 16'h0000} - {4'h0, r_rounds[15:0], 12'h000};
    end

    // shared 16x32 multiplier, circumference times a selected operand
    always_comb begin
        case (r_state)
            S_WMUL:  n_mul_b = r_rounds;
            S_DLO:   n_mul_b = r_session_wheel_count[31:0];
            S_DHI:   n_mul_b = {24'h000000, r_session_wheel_count[39:32]};
            S_DTOT:  n_mul_b = r_last_wheel_count;
            default: n_mul_b = r_rounds;
        endcase
        n_mul = 48'(r_circ) * 48'(n_mul_b);
    end

    // divider request
    always_comb begin
        n_div_req.start = (r_state == S_WSTART) || (r_state == S_CSTART);
        n_div_req.num   = r_num;
        n_div_req.den   = r_den;
    end

    cssc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (n_div_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ       <= WHEEL_CIRC_RST;
            r_speed_hold <= SPEED_HOLD_RST;
            r_cad_hold   <= CADENCE_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WHEEL_CIRC:   r_circ       <= i_cfg_data;
                CFG_SPEED_HOLD:   r_speed_hold <= i_cfg_data;
                CFG_CADENCE_HOLD: r_cad_hold   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // sequencer, measurement state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state               <= S_IDLE;
            r_out_valid           <= 1'b0;
            r_last_wheel_count    <= '0;
            r_last_wheel_ticks    <= '0;
            r_speed_started       <= 1'b0;
            r_held_speed          <= '0;
            r_wheel_seen_time     <= '0;
            r_last_nonzero_rounds <= '0;
            r_session_wheel_count <= '0;
            r_last_crank_count    <= '0;
            r_last_crank_ticks    <= '0;
            r_cadence_started     <= 1'b0;
            r_held_cadence        <= '0;
            r_crank_seen_time     <= '0;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_cmd   <= i_command;
                        r_wp    <= i_wheel_present && !i_command;
                        r_cp    <= i_crank_present && !i_command;
                        r_wrevs <= i_wheel_revs;
                        r_wtime <= i_wheel_event_time;
                        r_crevs <= i_crank_revs;
                        r_ctime <= i_crank_event_time;
                        r_now   <= i_now_seconds;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (r_cmd) begin
                        // reset command clears the session state
                        r_last_wheel_count    <= '0;
                        r_last_wheel_ticks    <= '0;
                        r_speed_started       <= 1'b0;
                        r_held_speed          <= '0;
                        r_wheel_seen_time     <= '0;
                        r_last_nonzero_rounds <= '0;
                        r_session_wheel_count <= '0;
                        r_last_crank_count    <= '0;
                        r_last_crank_ticks    <= '0;
                        r_cadence_started     <= 1'b0;
                        r_held_cadence        <= '0;
                        r_crank_seen_time     <= '0;
                        r_state               <= S_DLO;
                    end else if (r_wp) begin
                        r_state <= S_WHEEL;
                    end else if (r_cp) begin
                        r_state <= S_CRANK;
                    end else begin
                        r_state <= S_DLO;
                    end
                end
                // wheel: differences, first sample only primes
                S_WHEEL: begin
                    r_last_wheel_count <= r_wrevs;
                    r_last_wheel_ticks <= r_wtime;
                    r_rounds           <= n_wdiff[32] ? 32'd0 : n_wdiff[31:0];
                    r_ticks            <= r_wtime - r_last_wheel_ticks;
                    if (!r_speed_started) begin
                        r_speed_started   <= 1'b1;
                        r_held_speed      <= '0;
                        r_wheel_seen_time <= r_now;
                        r_state           <= r_cp ? S_CRANK : S_DLO;
                    end else begin
                        r_state <= S_WHOLD;
                    end
                end
                S_WHOLD: begin
                    if (r_rounds != 32'd0) begin
                        r_last_nonzero_rounds <= r_rounds;
                    end
                    r_session_wheel_count <= r_session_wheel_count + {8'h00, r_rounds};
                    r_hold  <= n_rz && (n_welapsed < {16'h0000, r_speed_hold});
                    r_state <= S_WADD;
                end
                S_WADD: begin
                    if (r_hold) begin
                        r_session_wheel_count <= r_session_wheel_count
                                                 + {8'h00, r_last_nonzero_rounds};
                    end
                    if (!n_rz) begin
                        r_state <= S_WMUL;
                    end else begin
                        if (!r_hold) begin
                            r_held_speed <= '0;
                        end
                        r_state <= r_cp ? S_CRANK : S_DLO;
                    end
                end
                // speed = circ * rounds * 9216 / (25 * ticks)
                S_WMUL: begin
                    r_prod  <= n_mul;
                    r_den   <= {1'b0, r_ticks, 4'h0} + {2'b00, r_ticks, 3'b000}
                               + {5'h00, r_ticks};
                    r_state <= S_WNUM;
                end
                S_WNUM: begin
                    r_num   <= {n_times9, 10'h000};
                    r_state <= S_WSTART;
                end
                S_WSTART: r_state <= S_WDIV;
                S_WDIV: begin
                    if (n_div_rsp.done) begin
                        r_held_speed      <= n_div_rsp.quo;
                        r_wheel_seen_time <= r_now;
                        r_state           <= r_cp ? S_CRANK : S_DLO;
                    end
                end
                // crank: differences modulo 2^16
                S_CRANK: begin
                    r_last_crank_count <= r_crevs;
                    r_last_crank_ticks <= r_ctime;
                    r_rounds           <= {16'h0000, n_cdiff};
                    r_ticks            <= r_ctime - r_last_crank_ticks;
                    if (!r_cadence_started) begin
                        r_cadence_started <= 1'b1;
                        r_held_cadence    <= '0;
                        r_crank_seen_time <= r_now;
                        r_state           <= S_DLO;
                    end else begin
                        r_state <= S_CHOLD;
                    end
                end
                S_CHOLD: begin
                    if (n_rz && (n_celapsed < {16'h0000, r_cad_hold})) begin
                        r_state <= S_DLO;
                    end else if (!n_rz) begin
                        // cadence = rounds * 61440 / ticks
                        r_num   <= {{(NUM_W-32){1'b0}}, n_cnum};
                        r_den   <= {{(DEN_W-16){1'b0}}, r_ticks};
                        r_state <= S_CSTART;
                    end else begin
                        r_held_cadence <= '0;
                        r_state        <= S_DLO;
                    end
                end
                S_CSTART: r_state <= S_CDIV;
                S_CDIV: begin
                    if (n_div_rsp.done) begin
                        r_held_cadence    <= n_div_rsp.quo;
                        r_crank_seen_time <= r_now;
                        r_state           <= S_DLO;
                    end
                end
                // distances through the shared multiplier
                S_DLO: begin
                    r_prod  <= n_mul;
                    r_state <= S_DHI;
                end
                S_DHI: begin
                    r_sess_dist <= r_prod;
                    r_prod      <= n_mul;
                    r_state     <= S_DTOT;
                end
                S_DTOT: begin
                    r_sess_dist[47:32] <= r_sess_dist[47:32] + r_prod[15:0];
                    r_prod             <= n_mul;
                    r_state            <= S_DONE;
                end
                S_DONE: begin
                    if (n_out_load) begin
                        r_o_speed   <= r_held_speed;
                        r_o_cadence <= r_held_cadence;
                        r_o_sess    <= r_sess_dist;
                        r_o_total   <= r_prod;
                        r_o_sv      <= r_wp;
                        r_o_cv      <= r_cp;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_speed_centi_kmh     = r_o_speed;
    assign o_cadence_rpm         = r_o_cadence;
    assign o_session_distance_mm = r_o_sess;
    assign o_total_distance_mm   = r_o_total;
    assign o_speed_valid         = r_o_sv;
    assign o_cadence_valid       = r_o_cv;

endmodule

### design/cssc_check.sv
// ----------------------------------------------------------------------------
// cssc_check
// Port-level checks of the cycling speed and cadence calculator.
// ----------------------------------------------------------------------------
module cssc_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  cssc_pkg::t_cfg_idx    i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic                  i_command,
    input  logic                  i_wheel_present,
    input  logic                  i_crank_present,
    input  logic [31:0]           i_wheel_revs,
    input  logic [15:0]           i_wheel_event_time,
    input  logic [15:0]           i_crank_revs,
    input  logic [15:0]           i_crank_event_time,
    input  logic [31:0]           i_now_seconds,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic [15:0]           o_speed_centi_kmh,
    input  logic [15:0]           o_cadence_rpm,
    input  logic [47:0]           o_session_distance_mm,
    input  logic [47:0]           o_total_distance_mm,
    input  logic                  o_speed_valid,
    input  logic                  o_cadence_valid
);
    import cssc_pkg::*;

    logic       n_in_acc;
    logic       n_out_acc;
    logic [1:0] r_cnt;
    logic [1:0] r_cmd;

    assign n_in_acc  = i_in_valid && !o_in_stall;
    assign n_out_acc = o_out_valid && !i_out_stall;

    // items in flight and their command flags, oldest in bit 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_cmd <= '0;
        end else begin
            case ({n_in_acc, n_out_acc})
                2'b10: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd0) begin
                        r_cmd[0] <= i_command;
                    end else begin
                        r_cmd[1] <= i_command;
                    end
                end
                2'b01: begin
                    r_cnt    <= r_cnt - 2'd1;
                    r_cmd[0] <= r_cmd[1];
                end
                2'b11: begin
                    if (r_cnt == 2'd1) begin
                        r_cmd[0] <= i_command;
                    end else begin
                        r_cmd[0] <= r_cmd[1];
                        r_cmd[1] <= i_command;
                    end
                end
                default: ;
            endcase
        end
    end

    // at most two items in flight, and never a result without an item
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && (!o_out_valid || (r_cnt != 2'd0)))
        else $error("result count does not match accepted items");

    // a reset command yields an all-zero result
    a_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_acc && r_cmd[0]) |->
            (o_speed_centi_kmh == 16'd0) && (o_cadence_rpm == 16'd0) &&
            (o_session_distance_mm == 48'd0) && (o_total_distance_mm == 48'd0) &&
            !o_speed_valid && !o_cadence_valid)
        else $error("reset command gave a nonzero result");

    // the unit works on one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_in_acc |=> o_in_stall)
        else $error("item accepted while busy");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_speed_centi_kmh) && $stable(o_cadence_rpm) &&
            $stable(o_session_distance_mm) && $stable(o_total_distance_mm))
        else $error("stalled result changed");

    // reset leaves no result pending and the unit not busy
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or busy after reset");

endmodule

bind cycling_speed_cadence_calc_unit cssc_check u_cssc_check (.*);
